@@ rtl/brl_pkg.sv @@
// Package for the bucket rate limiter: item structs, op and outcome codes, FSM states.
// Used by every module under rtl/.
package brl_pkg;

  localparam int NUM_BUCKETS_DEF = 64;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int BW = 6;
  localparam int TW = 24;
  localparam int CW = 12;

  typedef enum logic [1:0] {
    OP_REQ    = 2'd0,
    OP_REPORT = 2'd1,
    OP_TICK   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    OC_GRANT   = 2'd0,
    OC_QUEUED  = 2'd1,
    OC_DROPPED = 2'd2,
    OC_RELEASE = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [1:0]    op;
    logic [BW-1:0] bucket;
    logic [7:0]    request_tag;
    logic [CW-1:0] limit;
    logic [CW-1:0] remaining;
    logic [TW-1:0] reset_after_ms;
    logic          is_global;
  } in_item_t;

  typedef struct packed {
    logic [1:0]    outcome;
    logic [BW-1:0] out_bucket;
    logic [7:0]    out_tag;
    logic [TW-1:0] retry_after_ms;
    logic          last;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD,      // read bucket entry for request or report
    S_RDW,     // bucket entry data valid
    S_TRD,     // tick: read bucket entry
    S_TUPD,    // tick: update bucket entry
    S_GLOB,    // tick: global timer
    S_QRD,     // rescan: read queue entry
    S_QBRD,    // rescan: read queued bucket entry
    S_QDEC,    // rescan: decide keep or release
    S_OUT      // wait for result to be taken
  } state_t;

endpackage

@@ rtl/brl_table.sv @@
// Bucket state memory: limit, remaining and timer for each bucket (known/active live in the top level's flip-flops).
// One read port and one write port, registered read data. Depends on brl_pkg.
module brl_table
  import brl_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  localparam int AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1,
  localparam int EW = 2 + 2*CW + TW
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [EW-1:0] rd_data,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [EW-1:0] wr_data
);

  logic [EW-1:0] mem [NUM_BUCKETS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/brl_queue.sv @@
// Request queue memory holding bucket and tag of each waiting request.
// One read and one write port, registered read data. Depends on brl_pkg.
module brl_queue
  import brl_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic            clk,
  input  logic [QW-1:0]   rd_addr,
  output logic [BW+7:0]   rd_data,
  input  logic            wr_en,
  input  logic [QW-1:0]   wr_addr,
  input  logic [BW+7:0]   wr_data
);

  logic [BW+7:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/bucket_rate_limiter.sv @@
// Bucket rate limiter top level: sequencer, shared timer/compare unit and the two memories.
// Request and report pass through S_RD and S_RDW; a request then waits in S_OUT for the
// result handshake. A tick walks every bucket (S_TRD, S_TUPD), then updates the global
// timer in S_GLOB and, if a timer expired and the queue is not empty, rescans the queue
// (S_QRD, S_QBRD, S_QDEC per entry) with a result handshake per release and a re-read of
// the entry that follows a held release. Ready only in the idle state; one item at a time.
// Synchronous active-low reset clears control, global state and the per-bucket
// known/active bits; limits, counts, timers and queue entries are written before use.
module bucket_rate_limiter
  import brl_pkg::*;
#(
  parameter int NUM_BUCKETS = NUM_BUCKETS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int AW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
  localparam int BIW = $clog2(NUM_BUCKETS + 1);
  localparam int EW = 2*CW + TW;

  state_t state_r, state_nxt;
  in_item_t item_r, item_nxt;
  out_item_t res_r, res_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [NUM_BUCKETS-1:0] known_r, known_nxt, active_r, active_nxt;
  logic glob_r, glob_nxt;
  logic [TW-1:0] gtimer_r, gtimer_nxt;
  logic [CNTW-1:0] qcount_r, qcount_nxt, qidx_r, qidx_nxt, kept_r, kept_nxt;
  logic [BIW-1:0] bidx_r, bidx_nxt;
  logic fired_r, fired_nxt;
  logic more_r, more_nxt;   // a release waits in res_r until its last flag is known
  logic [BW+7:0] qent_r, qent_nxt;
  state_t ret_r, ret_nxt;

  logic [AW-1:0] t_raddr, t_waddr;
  logic [EW+1:0] t_rdata, t_wdata;
  logic t_we;
  logic [QW-1:0] q_raddr, q_waddr;
  logic [BW+7:0] q_rdata, q_wdata;
  logic q_we;

  brl_table #(.NUM_BUCKETS(NUM_BUCKETS)) u_table (
    .clk(clk), .rd_addr(t_raddr), .rd_data(t_rdata),
    .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata)
  );

  brl_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
    .clk(clk), .rd_addr(q_raddr), .rd_data(q_rdata),
    .wr_en(q_we), .wr_addr(q_waddr), .wr_data(q_wdata)
  );

  // Memory word fields; the two top bits are unused (flags live in flip-flops).
  logic [CW-1:0] e_lim, e_rem;
  logic [TW-1:0] e_tmr;
  assign e_lim = t_rdata[EW-1 -: CW];
  assign e_rem = t_rdata[EW-CW-1 -: CW];
  assign e_tmr = t_rdata[TW-1:0];

  // Shared compare/decrement unit on the timer read back, or on the global timer in S_GLOB.
  logic tmr_expire;
  logic [TW-1:0] tmr_dec;
  logic [TW-1:0] tsel;
  always_comb begin
    tsel = (state_r == S_GLOB) ? gtimer_r : e_tmr;
    tmr_expire = (tsel <= TW'(1));
    tmr_dec = tsel - TW'(1);
  end

  logic [BW-1:0] cur_b;
  logic in_rng, kn, ac, blocked;
  always_comb begin
    cur_b = (state_r == S_QDEC || state_r == S_QBRD) ? qent_r[BW+7:8] : item_r.bucket;
    in_rng = ({{(32-BW){1'b0}}, cur_b} < NUM_BUCKETS);
    kn = in_rng && known_r[AW'(cur_b)];
    ac = in_rng && active_r[AW'(cur_b)];
    blocked = glob_r || (kn && (e_rem == '0) && ac);
  end

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      known_r <= '0;
      active_r <= '0;
      glob_r <= 1'b0;
      gtimer_r <= '0;
      qcount_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      known_r <= known_nxt;
      active_r <= active_nxt;
      glob_r <= glob_nxt;
      gtimer_r <= gtimer_nxt;
      qcount_r <= qcount_nxt;
      out_valid_r <= out_valid_nxt;
    end
    item_r <= item_nxt;
    res_r <= res_nxt;
    qidx_r <= qidx_nxt;
    kept_r <= kept_nxt;
    bidx_r <= bidx_nxt;
    fired_r <= fired_nxt;
    more_r <= more_nxt;
    qent_r <= qent_nxt;
    ret_r <= ret_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    item_nxt = item_r;
    res_nxt = res_r;
    out_valid_nxt = out_valid_r;
    known_nxt = known_r;
    active_nxt = active_r;
    glob_nxt = glob_r;
    gtimer_nxt = gtimer_r;
    qcount_nxt = qcount_r;
    qidx_nxt = qidx_r;
    kept_nxt = kept_r;
    bidx_nxt = bidx_r;
    fired_nxt = fired_r;
    more_nxt = more_r;
    qent_nxt = qent_r;
    ret_nxt = ret_r;
    t_raddr = AW'(cur_b);
    t_we = 1'b0;
    t_waddr = AW'(cur_b);
    t_wdata = t_rdata;
    q_raddr = QW'(qidx_r);
    q_we = 1'b0;
    q_waddr = QW'(kept_r);
    q_wdata = qent_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt = in_data;
          unique case (in_data.op)
            OP_REQ, OP_REPORT: state_nxt = S_RD;
            OP_TICK: begin
              bidx_nxt = '0;
              fired_nxt = 1'b0;
              state_nxt = S_TRD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_RD: state_nxt = S_RDW;
      S_RDW: begin
        if (item_r.op == OP_REQ) begin
          res_nxt.out_bucket = item_r.bucket;
          res_nxt.out_tag = item_r.request_tag;
          res_nxt.last = 1'b1;
          res_nxt.retry_after_ms = '0;
          if (!blocked) begin
            res_nxt.outcome = OC_GRANT;
            if (kn && e_rem != '0) begin
              t_we = 1'b1;
              t_wdata = {2'b00, e_lim, e_rem - CW'(1), e_tmr};
            end
          end else if (qcount_r >= CNTW'(QUEUE_DEPTH)) begin
            res_nxt.outcome = OC_DROPPED;
          end else begin
            res_nxt.outcome = OC_QUEUED;
            res_nxt.retry_after_ms = glob_r ? gtimer_r : (ac ? e_tmr : '0);
            q_we = 1'b1;
            q_waddr = QW'(qcount_r);
            q_wdata = {item_r.bucket, item_r.request_tag};
            qcount_nxt = qcount_r + CNTW'(1);
          end
          out_valid_nxt = 1'b1;
          more_nxt = 1'b0;
          ret_nxt = S_IDLE;
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_IDLE;
          if (item_r.is_global && item_r.remaining == '0) begin
            glob_nxt = 1'b1;
            gtimer_nxt = item_r.reset_after_ms;
          end else if (in_rng) begin
            known_nxt[AW'(cur_b)] = 1'b1;
            t_we = 1'b1;
            t_wdata = {2'b00, item_r.limit, item_r.remaining, e_tmr};
            if (item_r.remaining == '0 && item_r.reset_after_ms != '0) begin
              t_wdata[TW-1:0] = item_r.reset_after_ms;
              active_nxt[AW'(cur_b)] = 1'b1;
            end
          end
        end
      end
      S_TRD: begin
        t_raddr = AW'(bidx_r);
        state_nxt = S_TUPD;
      end
      S_TUPD: begin
        t_waddr = AW'(bidx_r);
        if (active_r[AW'(bidx_r)]) begin
          t_we = 1'b1;
          if (tmr_expire) begin
            t_wdata = {2'b00, e_lim, e_lim, {TW{1'b0}}};
            active_nxt[AW'(bidx_r)] = 1'b0;
            fired_nxt = 1'b1;
          end else begin
            t_wdata = {2'b00, e_lim, e_rem, tmr_dec};
          end
        end
        bidx_nxt = bidx_r + BIW'(1);
        state_nxt = (bidx_r == BIW'(NUM_BUCKETS - 1)) ? S_GLOB : S_TRD;
      end
      S_GLOB: begin
        if (glob_r) begin
          if (tmr_expire) begin
            gtimer_nxt = '0;
            glob_nxt = 1'b0;
            fired_nxt = 1'b1;
          end else begin
            gtimer_nxt = tmr_dec;
          end
        end
        qidx_nxt = '0;
        kept_nxt = '0;
        more_nxt = 1'b0;
        if ((fired_r || (glob_r && tmr_expire)) && qcount_r != '0) begin
          state_nxt = S_QRD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_QRD: begin
        q_raddr = QW'(qidx_r);
        state_nxt = S_QBRD;
      end
      S_QBRD: begin
        qent_nxt = q_rdata;
        t_raddr = AW'(q_rdata[BW+7:8]);
        state_nxt = S_QDEC;
      end
      S_QDEC: begin
        if (blocked) begin
          q_we = 1'b1;
          kept_nxt = kept_r + CNTW'(1);
        end else if (more_r) begin
          // Another release follows, so the held one goes out with last clear and
          // this entry is read again afterwards.
          out_valid_nxt = 1'b1;
          more_nxt = 1'b0;
          ret_nxt = S_QRD;
          state_nxt = S_OUT;
        end else begin
          if (kn && e_rem != '0) begin
            t_we = 1'b1;
            t_wdata = {2'b00, e_lim, e_rem - CW'(1), e_tmr};
          end
          res_nxt.outcome = OC_RELEASE;
          res_nxt.out_bucket = qent_r[BW+7:8];
          res_nxt.out_tag = qent_r[7:0];
          res_nxt.retry_after_ms = '0;
          res_nxt.last = 1'b0;
          more_nxt = 1'b1;
        end
        if (blocked || !more_r) begin
          qidx_nxt = qidx_r + CNTW'(1);
          if (qidx_r + CNTW'(1) >= qcount_r) begin
            qcount_nxt = blocked ? kept_r + CNTW'(1) : kept_r;
            more_nxt = 1'b0;
            if (!blocked || more_r) begin
              // The release in res_r is the final result of the tick.
              res_nxt.last = 1'b1;
              out_valid_nxt = 1'b1;
              ret_nxt = S_IDLE;
              state_nxt = S_OUT;
            end else begin
              state_nxt = S_IDLE;
            end
          end else begin
            state_nxt = S_QRD;
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          out_valid_nxt = 1'b0;
          state_nxt = ret_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

@@ tb/brl_checker.sv @@
// Scoreboard for the bucket rate limiter: tracks bucket, global block and queue state,
// predicts the results of every accepted item and compares them with the output channel.
// Depends on brl_pkg for the item structs and the op and outcome codes.
module brl_checker
  import brl_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_ready,
  input  in_item_t  in_data,
  input  logic      out_valid,
  input  logic      out_ready,
  input  out_item_t out_data,
  output int        fail_count,
  output int        pending
);

  localparam int NB = NUM_BUCKETS_DEF;
  localparam int QD = QUEUE_DEPTH_DEF;

  logic          known [NB];
  logic [CW-1:0] lim_r [NB];
  logic [CW-1:0] rem_r [NB];
  logic [TW-1:0] tmr   [NB];
  logic          tmr_on[NB];
  logic          gblk;
  logic [TW-1:0] gtmr;
  logic [BW-1:0] wait_bucket[QD];
  logic [7:0]    wait_tag[QD];
  int            wait_cnt;
  out_item_t     outcome_q[$];

  assign pending = outcome_q.size();

  function automatic bit is_held(logic [BW-1:0] b);
    return gblk || (known[b] && rem_r[b] == 0 && tmr_on[b]);
  endfunction

  function automatic void take_credit(logic [BW-1:0] b);
    if (known[b] && rem_r[b] != 0) rem_r[b] = rem_r[b] - 1'b1;
  endfunction

  function automatic void add_outcome(outcome_t oc, logic [BW-1:0] b, logic [7:0] tag,
                                      logic [TW-1:0] retry);
    out_item_t r;
    r.outcome        = oc;
    r.out_bucket     = b;
    r.out_tag        = tag;
    r.retry_after_ms = retry;
    r.last           = 1'b0;
    outcome_q.push_back(r);
  endfunction

  function automatic void predict_item(in_item_t it);
    int   base;
    int   kept;
    bit   fired;
    base  = outcome_q.size();
    kept  = 0;
    fired = 0;
    case (op_t'(it.op))
      OP_REQ: begin
        if (!is_held(it.bucket)) begin
          take_credit(it.bucket);
          add_outcome(OC_GRANT, it.bucket, it.request_tag, '0);
        end else if (wait_cnt >= QD) begin
          add_outcome(OC_DROPPED, it.bucket, it.request_tag, '0);
        end else begin
          add_outcome(OC_QUEUED, it.bucket, it.request_tag,
                      gblk ? gtmr : (tmr_on[it.bucket] ? tmr[it.bucket] : '0));
          wait_bucket[wait_cnt] = it.bucket;
          wait_tag[wait_cnt]    = it.request_tag;
          wait_cnt++;
        end
      end
      OP_REPORT: begin
        if (it.is_global && it.remaining == 0) begin
          gblk = 1'b1;
          gtmr = it.reset_after_ms;
        end else begin
          known[it.bucket] = 1'b1;
          lim_r[it.bucket] = it.limit;
          rem_r[it.bucket] = it.remaining;
          if (it.remaining == 0 && it.reset_after_ms != 0) begin
            tmr[it.bucket]    = it.reset_after_ms;
            tmr_on[it.bucket] = 1'b1;
          end
        end
      end
      OP_TICK: begin
        for (int i = 0; i < NB; i++) begin
          if (tmr_on[i]) begin
            if (tmr[i] <= 1) begin
              tmr[i]    = '0;
              tmr_on[i] = 1'b0;
              rem_r[i]  = lim_r[i];
              fired     = 1;
            end else begin
              tmr[i] = tmr[i] - 1'b1;
            end
          end
        end
        if (gblk) begin
          if (gtmr <= 1) begin
            gtmr  = '0;
            gblk  = 1'b0;
            fired = 1;
          end else begin
            gtmr = gtmr - 1'b1;
          end
        end
        if (fired) begin
          // Queued requests that are still blocked keep their order.
          for (int i = 0; i < wait_cnt; i++) begin
            if (is_held(wait_bucket[i])) begin
              wait_bucket[kept] = wait_bucket[i];
              wait_tag[kept]    = wait_tag[i];
              kept++;
            end else begin
              take_credit(wait_bucket[i]);
              add_outcome(OC_RELEASE, wait_bucket[i], wait_tag[i], '0);
            end
          end
          wait_cnt = kept;
        end
      end
      default: ;
    endcase
    if (outcome_q.size() > base) outcome_q[outcome_q.size()-1].last = 1'b1;
  endfunction

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < NB; i++) begin
        known[i]  = 1'b0;
        tmr[i]    = '0;
        tmr_on[i] = 1'b0;
      end
      gblk       = 1'b0;
      gtmr       = '0;
      wait_cnt   = 0;
      fail_count = 0;
      outcome_q.delete();
    end else begin
      if (in_valid && in_ready) predict_item(in_data);
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          $error("result with none expected: outcome %0d bucket %0d tag %0d",
                 out_data.outcome, out_data.out_bucket, out_data.out_tag);
          fail_count++;
        end else begin
          exp_r = outcome_q.pop_front();
          if (out_data.outcome !== exp_r.outcome) begin
            $error("outcome: expected %0d, got %0d", exp_r.outcome, out_data.outcome);
            fail_count++;
          end
          if (out_data.out_bucket !== exp_r.out_bucket) begin
            $error("out_bucket: expected %0d, got %0d", exp_r.out_bucket,
                   out_data.out_bucket);
            fail_count++;
          end
          if (out_data.out_tag !== exp_r.out_tag) begin
            $error("out_tag: expected %0d, got %0d", exp_r.out_tag, out_data.out_tag);
            fail_count++;
          end
          if (out_data.retry_after_ms !== exp_r.retry_after_ms) begin
            $error("retry_after_ms: expected %0d, got %0d", exp_r.retry_after_ms,
                   out_data.retry_after_ms);
            fail_count++;
          end
          if (out_data.last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, out_data.last);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

@@ tb/tb_bucket_rate_limiter.sv @@
// Top of the bucket rate limiter testbench: clock, reset, stimulus and receiver stalls.
// Depends on brl_pkg, the bucket_rate_limiter RTL and brl_checker.
module tb_bucket_rate_limiter;
  import brl_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;
  int        fail_count;
  int        pending;
  int        cycles;
  int        snd_idle;
  int        rcv_idle;
  bit        hold_go;

  bucket_rate_limiter DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  brl_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 0;
        out_ready <= 1'b0;
        repeat (400) @(negedge clk);
      end
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  function automatic in_item_t mk_item(op_t op, int b, int tag, int lim, int rem,
                                       int rst, bit glob);
    in_item_t it;
    it.op             = op;
    it.bucket         = b[BW-1:0];
    it.request_tag    = tag[7:0];
    it.limit          = lim[CW-1:0];
    it.remaining      = rem[CW-1:0];
    it.reset_after_ms = rst[TW-1:0];
    it.is_global      = glob;
    return it;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(in_item_t it);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // Most traffic targets a few buckets so that reports and timers affect requests.
  function automatic in_item_t rand_item();
    int sel;
    int b;
    int rem;
    sel = $urandom_range(99);
    b   = ($urandom_range(9) < 8) ? $urandom_range(7) : $urandom_range(63);
    if (sel < 36) return mk_item(OP_REQ, b, $urandom_range(255), 0, 0, 0, 0);
    if (sel < 42)
      return mk_item(OP_REPORT, b, $urandom, $urandom, 0, $urandom_range(6), 1);
    if (sel < 58) begin
      // Long timers only go with a nonzero count, so no bucket stays blocked forever.
      rem = ($urandom_range(1) == 0) ? 0 :
            (($urandom_range(3) == 0) ? $urandom_range(4095, 1) : $urandom_range(4, 1));
      return mk_item(OP_REPORT, b, $urandom,
                     ($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(5),
                     rem, (rem == 0) ? $urandom_range(8) : $urandom, $urandom_range(1));
    end
    if (sel < 96) return mk_item(OP_TICK, b, $urandom, $urandom, $urandom, $urandom, 0);
    return mk_item(OP_NONE, b, $urandom, $urandom, $urandom, $urandom, $urandom_range(1));
  endfunction

  initial begin
    cycles   = 0;
    hold_go  = 0;
    snd_idle = 22;
    rcv_idle = 59;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part.
    send_item(mk_item(OP_REQ, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_REPORT, 63, 8'hA5, 4095, 5, 24'hFFFFFF, 0));
    send_item(mk_item(OP_REQ, 63, 255, 0, 0, 0, 0));
    send_item(mk_item(OP_REPORT, 1, 0, 2, 0, 2, 0));
    send_item(mk_item(OP_REQ, 1, 17, 0, 0, 0, 0));
    send_item(mk_item(OP_NONE, 63, 255, 4095, 4095, 24'hFFFFFF, 1));
    // Global block with zero time lifts at the next tick.
    send_item(mk_item(OP_REPORT, 5, 0, 0, 0, 0, 1));
    send_item(mk_item(OP_REQ, 2, 34, 0, 0, 0, 0));
    send_item(mk_item(OP_TICK, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_TICK, 0, 0, 0, 0, 0, 0));
    // Fill the queue under a global block, overflow it, then release all at once.
    send_item(mk_item(OP_REPORT, 0, 0, 0, 0, 2, 1));
    for (int i = 0; i < 17; i++)
      send_item(mk_item(OP_REQ, i * 4, 100 + i, 0, 0, 0, 0));
    send_item(mk_item(OP_TICK, 0, 0, 0, 0, 0, 0));
    send_item(mk_item(OP_TICK, 0, 0, 0, 0, 0, 0));

    for (int i = 0; i < 160; i++) send_item(rand_item());

    // Sender pause until every result has been taken.
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
    snd_idle = 59;
    rcv_idle = 22;
    hold_go  = 1;
    for (int i = 0; i < 160; i++) send_item(rand_item());

    snd_idle = 0;
    rcv_idle = 0;
    for (int i = 0; i < 160; i++) send_item(rand_item());
    in_valid <= 1'b0;

    wait (pending == 0);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
